// File: hdl/variance_stddev_reduce_macros.svh
// Assertion macros for the variance/std-dev reduce block.
// Used by variance_stddev_reduce.sv; needs clk and rst_n in scope.
`ifndef VARIANCE_STDDEV_REDUCE_MACROS_SVH
`define VARIANCE_STDDEV_REDUCE_MACROS_SVH

// same-cycle implication
`define VSR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vsr check failed");

// next-cycle implication
`define VSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vsr check failed");

`endif

// File: hdl/vsr_pkg.sv
// Shared types and constants for the variance/std-dev reduce block.
// No dependencies.
package vsr_pkg;

  localparam int SAMPLE_W = 32;
  localparam int VAR_W    = 48;
  localparam int STD_W    = 32;
  localparam int CORR_W   = 10;
  localparam int APB_AW   = 3;

  localparam logic [CORR_W-1:0] CORR_RESET = 10'd1;
  localparam logic [VAR_W-1:0]  VAR_MAX    = {VAR_W{1'b1}};
  localparam logic [STD_W-1:0]  STD_MAX    = {STD_W{1'b1}};

  // register index taken from paddr[2]
  localparam logic REG_CORRECTION = 1'b0;

  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001,
    S_MSET = 7'b0000010,
    S_MDIV = 7'b0000100,
    S_SQ   = 7'b0001000,
    S_VDIV = 7'b0010000,
    S_SQRT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

endpackage

// File: hdl/vsr_in_if.sv
// Sample input channel: valid/ready plus sample and last marker.
// Depends on vsr_pkg.
interface vsr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vsr_pkg::SAMPLE_W-1:0] sample;
  logic                                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// File: hdl/vsr_out_if.sv
// Result channel: valid/ready plus mean, variance, std_dev, empty flag.
// Depends on vsr_pkg.
interface vsr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [vsr_pkg::SAMPLE_W-1:0] mean;
  logic        [vsr_pkg::VAR_W-1:0]    variance;
  logic        [vsr_pkg::STD_W-1:0]    std_dev;
  logic                                empty_set;

  modport source (output valid, output mean, output variance, output std_dev,
                  output empty_set, input ready);
  modport sink   (input valid, input mean, input variance, input std_dev,
                  input empty_set, output ready);
endinterface

// File: hdl/variance_stddev_reduce.sv
// Two-pass sample variance / standard deviation over a block of Q16.16 samples.
// Depends on vsr_pkg, vsr_in_if, vsr_out_if, variance_stddev_reduce_macros.svh.
//
// Usage:
//   in_chan  : one signed Q16.16 sample per item; last=1 closes the set.
//   out_chan : one result per set (mean, variance, std_dev, empty_set).
//   cfg_*    : APB register 0 = correction (10 bits, reset 1), pready tied high.
// Samples load at one item per cycle into a MAX_SAMPLES-deep RAM while
// being summed; samples past MAX_SAMPLES are dropped.
// After the last item the block stops taking items and runs, on one
// restoring divider and one digit-by-digit root unit: a setup step,
// the mean divide (DW = 65 + clog2(MAX+1)), the squared-deviation pass
// (RAM read, subtract, multiply, accumulate), the variance divide and the
// root, then a result register.
// When the variance saturates the root is skipped.
// The divider iterates one bit per cycle.
// Reset clears count, sum and state; RAM contents are not cleared.
// A stalled receiver holds the result; the next set may load and be computed
// meanwhile, but its result then waits in the block, which takes no items
// until the previous result is taken.
module variance_stddev_reduce #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  vsr_in_if.sink                      in_chan,
  vsr_out_if.source                   out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [vsr_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

`include "variance_stddev_reduce_macros.svh"

  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int SW  = 32 + CW;
  localparam int QW  = 64 + CW;
  localparam int DW  = QW + 1;
  localparam int DVW = CW + 16;
  localparam int RW  = DVW + 1;
  localparam int IW  = $clog2(DW + 1);
  localparam int XW  = (CW > vsr_pkg::CORR_W) ? CW : vsr_pkg::CORR_W;

  vsr_pkg::state_t state_r, state_nxt;

  logic [vsr_pkg::CORR_W-1:0] corr_r, corr_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic signed [SW-1:0]       sum_r, sum_nxt;
  logic                       neg_r, neg_nxt;
  logic                       emp_r, emp_nxt;

  logic [DW-1:0]  dvd_r, dvd_nxt;
  logic [RW-1:0]  rem_r, rem_nxt;
  logic [DVW-1:0] dvs_r, dvs_nxt;
  logic [IW-1:0]  iter_r, iter_nxt;

  logic signed [31:0] mean_r, mean_nxt;
  logic [47:0]        var_r, var_nxt;
  logic [31:0]        std_r, std_nxt;

  logic [CW-1:0]      rdp_r, rdp_nxt;
  logic [31:0]        rdat_r;
  logic               v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic [31:0]        absd_r, absd_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [QW-1:0]      ssd_r, ssd_nxt;

  logic [63:0]        rad_r, rad_nxt;
  logic [31:0]        root_r, root_nxt;
  logic [33:0]        srem_r, srem_nxt;

  logic               ov_r, ov_nxt;
  logic signed [31:0] o_mean_r, o_mean_nxt;
  logic [47:0]        o_var_r, o_var_nxt;
  logic [31:0]        o_std_r, o_std_nxt;
  logic               o_emp_r, o_emp_nxt;

  logic [31:0] mem [MAX_SAMPLES];

  logic in_fire, room, mem_we, cfg_we;
  logic [RW-1:0]  rem_sh;
  logic [RW:0]    rem_diff;
  logic           div_ge;
  logic [35:0]    srem_sh, sq_diff;
  logic           sq_ge;
  logic [SW-1:0]  sum_mag;
  logic [SW:0]    mean_dvd;
  logic [32:0]    q33;
  logic signed [32:0] dev;
  logic [CW-1:0]  den;
  logic           sat;
  logic [32:0]    root_rnd;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == vsr_pkg::REG_CORRECTION);
  assign cfg_prdata = (cfg_paddr[2] == vsr_pkg::REG_CORRECTION)
                      ? {{(32 - vsr_pkg::CORR_W){1'b0}}, corr_r} : 32'd0;

  assign in_chan.ready = (state_r == vsr_pkg::S_LOAD);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign room          = (cnt_r != CW'(MAX_SAMPLES));
  assign mem_we        = in_fire && room;

  assign out_chan.valid     = ov_r;
  assign out_chan.mean      = o_mean_r;
  assign out_chan.variance  = o_var_r;
  assign out_chan.std_dev   = o_std_r;
  assign out_chan.empty_set = o_emp_r;

  // shared restoring divider step
  assign rem_sh   = {rem_r[RW-2:0], dvd_r[DW-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign div_ge   = !rem_diff[RW];

  // root step
  assign srem_sh = {srem_r, rad_r[63:62]};
  assign sq_diff = srem_sh - {2'b00, root_r, 2'b01};
  assign sq_ge   = !sq_diff[35];

  assign sum_mag  = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign mean_dvd = {1'b0, sum_mag} + (SW + 1)'(cnt_r >> 1);
  assign q33      = dvd_r[32:0];
  assign dev      = 33'(signed'(rdat_r)) - 33'(mean_r);
  assign den      = (XW'(cnt_r) > XW'(corr_r)) ? CW'(XW'(cnt_r) - XW'(corr_r))
                                               : CW'(1);
  assign sat      = |dvd_r[DW-1:48];
  assign root_rnd = {1'b0, root_r} + ((34'(srem_r) > 34'(root_r)) ? 33'd1 : 33'd0);

  always_comb begin
    state_nxt  = state_r;
    corr_nxt   = cfg_we ? cfg_pwdata[vsr_pkg::CORR_W-1:0] : corr_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    neg_nxt    = neg_r;
    emp_nxt    = emp_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    iter_nxt   = iter_r;
    mean_nxt   = mean_r;
    var_nxt    = var_r;
    std_nxt    = std_r;
    rdp_nxt    = rdp_r;
    v1_nxt     = 1'b0;
    v2_nxt     = v1_r;
    v3_nxt     = v2_r;
    absd_nxt   = dev[32] ? 32'(-dev) : dev[31:0];
    prod_nxt   = 64'(absd_r) * 64'(absd_r);
    ssd_nxt    = ssd_r;
    rad_nxt    = rad_r;
    root_nxt   = root_r;
    srem_nxt   = srem_r;
    ov_nxt     = ov_r && !out_chan.ready;
    o_mean_nxt = o_mean_r;
    o_var_nxt  = o_var_r;
    o_std_nxt  = o_std_r;
    o_emp_nxt  = o_emp_r;

    unique case (state_r)
      vsr_pkg::S_LOAD: begin
        if (mem_we) begin
          cnt_nxt = cnt_r + CW'(1);
          sum_nxt = sum_r + SW'(in_chan.sample);
        end
        if (in_fire && in_chan.last) begin
          state_nxt = vsr_pkg::S_MSET;
        end
      end
      vsr_pkg::S_MSET: begin
        emp_nxt  = (cnt_r == '0);
        neg_nxt  = sum_r[SW-1];
        dvd_nxt  = DW'(mean_dvd);
        rem_nxt  = '0;
        dvs_nxt  = DVW'(cnt_r);
        iter_nxt = '0;
        if (cnt_r == '0) begin
          mean_nxt  = '0;
          var_nxt   = '0;
          std_nxt   = '0;
          state_nxt = vsr_pkg::S_DONE;
        end else begin
          state_nxt = vsr_pkg::S_MDIV;
        end
      end
      vsr_pkg::S_MDIV: begin
        if (iter_r != IW'(DW)) begin
          dvd_nxt  = {dvd_r[DW-2:0], div_ge};
          rem_nxt  = div_ge ? rem_diff[RW-1:0] : rem_sh;
          iter_nxt = iter_r + IW'(1);
        end else begin
          if (neg_r) begin
            mean_nxt = (q33 > 33'h080000000) ? 32'sh80000000 : 32'(-q33);
          end else begin
            mean_nxt = (q33 > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : q33[31:0];
          end
          rdp_nxt   = '0;
          ssd_nxt   = '0;
          state_nxt = vsr_pkg::S_SQ;
        end
      end
      vsr_pkg::S_SQ: begin
        if (rdp_r != cnt_r) begin
          v1_nxt  = 1'b1;
          rdp_nxt = rdp_r + CW'(1);
        end
        if (v3_r) begin
          ssd_nxt = ssd_r + QW'(prod_r);
        end
        if (rdp_r == cnt_r && !v1_r && !v2_r && !v3_r) begin
          dvd_nxt   = DW'(ssd_r) + (DW'(den) << 15);
          dvs_nxt   = DVW'(den) << 16;
          rem_nxt   = '0;
          iter_nxt  = '0;
          state_nxt = vsr_pkg::S_VDIV;
        end
      end
      vsr_pkg::S_VDIV: begin
        if (iter_r != IW'(DW)) begin
          dvd_nxt  = {dvd_r[DW-2:0], div_ge};
          rem_nxt  = div_ge ? rem_diff[RW-1:0] : rem_sh;
          iter_nxt = iter_r + IW'(1);
        end else begin
          var_nxt  = sat ? vsr_pkg::VAR_MAX : dvd_r[47:0];
          rad_nxt  = {dvd_r[47:0], 16'h0000};
          root_nxt = '0;
          srem_nxt = '0;
          iter_nxt = '0;
          if (sat) begin
            std_nxt   = vsr_pkg::STD_MAX;
            state_nxt = vsr_pkg::S_DONE;
          end else begin
            state_nxt = vsr_pkg::S_SQRT;
          end
        end
      end
      vsr_pkg::S_SQRT: begin
        if (iter_r != IW'(32)) begin
          srem_nxt = sq_ge ? sq_diff[33:0] : srem_sh[33:0];
          root_nxt = {root_r[30:0], sq_ge};
          rad_nxt  = {rad_r[61:0], 2'b00};
          iter_nxt = iter_r + IW'(1);
        end else begin
          std_nxt   = root_rnd[32] ? vsr_pkg::STD_MAX : root_rnd[31:0];
          state_nxt = vsr_pkg::S_DONE;
        end
      end
      vsr_pkg::S_DONE: begin
        if (!ov_r || out_chan.ready) begin
          ov_nxt     = 1'b1;
          o_mean_nxt = mean_r;
          o_var_nxt  = var_r;
          o_std_nxt  = std_r;
          o_emp_nxt  = emp_r;
          cnt_nxt    = '0;
          sum_nxt    = '0;
          state_nxt  = vsr_pkg::S_LOAD;
        end
      end
      default: begin
        state_nxt = vsr_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vsr_pkg::S_LOAD;
      corr_r  <= vsr_pkg::CORR_RESET;
      cnt_r   <= '0;
      sum_r   <= '0;
      iter_r  <= '0;
      rdp_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      ov_r    <= 1'b0;
      emp_r   <= 1'b0;
      neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      corr_r  <= corr_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      iter_r  <= iter_nxt;
      rdp_r   <= rdp_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
      v3_r    <= v3_nxt;
      ov_r    <= ov_nxt;
      emp_r   <= emp_nxt;
      neg_r   <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    mean_r   <= mean_nxt;
    var_r    <= var_nxt;
    std_r    <= std_nxt;
    absd_r   <= absd_nxt;
    prod_r   <= prod_nxt;
    ssd_r    <= ssd_nxt;
    rad_r    <= rad_nxt;
    root_r   <= root_nxt;
    srem_r   <= srem_nxt;
    o_mean_r <= o_mean_nxt;
    o_var_r  <= o_var_nxt;
    o_std_r  <= o_std_nxt;
    o_emp_r  <= o_emp_nxt;
  end

  // sample RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AW-1:0]] <= in_chan.sample;
    end
    rdat_r <= mem[rdp_r[AW-1:0]];
  end

  `VSR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_SAMPLES))
  `VSR_ASSERT_NEXT(a_last_stops, in_fire && in_chan.last, state_r == vsr_pkg::S_MSET)
  `VSR_ASSERT_NOW(a_empty_zero, ov_r && o_emp_r, o_mean_r == 0 && o_var_r == 0 && o_std_r == 0)
  `VSR_ASSERT_NOW(a_pass_in_sq, v1_r, state_r == vsr_pkg::S_SQ)

endmodule

// File: tb/vsr_result_checker.sv
// Result checker for variance_stddev_reduce: follows the input, result and
// register traffic, predicts each result and compares it. Needs vsr_pkg and both interfaces.
module vsr_result_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  vsr_in_if                          in_mon,
  vsr_out_if                         out_mon,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic                       cfg_pready,
  input  logic [vsr_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output int                         mismatches,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;

  typedef struct packed {
    logic signed [vsr_pkg::SAMPLE_W-1:0] mean;
    logic [vsr_pkg::VAR_W-1:0]           variance;
    logic [vsr_pkg::STD_W-1:0]           std_dev;
    logic                                empty_set;
  } stats_t;

  logic signed [vsr_pkg::SAMPLE_W-1:0] set_samples [DEPTH];
  int                                  set_len;
  longint                              set_sum;
  logic [vsr_pkg::CORR_W-1:0]          corr;
  stats_t                              stats_due [$];

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v, output logic [63:0] rem);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    rem = v;
    return root;
  endfunction

  function automatic stats_t set_stats();
    stats_t      r;
    longint      m;
    longint      half;
    longint      d;
    logic [63:0] mag;
    logic [127:0] sumsq;
    logic [127:0] den;
    logic [127:0] q;
    logic [63:0] root;
    logic [63:0] rem;
    r = '0;
    if (set_len == 0) begin
      r.empty_set = 1'b1;
      return r;
    end
    half = set_len / 2;
    if (set_sum >= 0) m = (set_sum + half) / set_len;
    else m = -((-set_sum + half) / set_len);
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    sumsq = 0;
    for (int i = 0; i < set_len; i++) begin
      d = longint'(set_samples[i]) - m;
      mag = (d < 0) ? 64'(-d) : 64'(d);
      sumsq = sumsq + 128'(mag * mag);
    end
    den = (set_len > int'(corr)) ? 128'(set_len - int'(corr)) : 128'd1;
    den = den << 16;
    q = (sumsq + (den >> 1)) / den;
    r.mean = m[31:0];
    if (q > 128'(vsr_pkg::VAR_MAX)) begin
      r.variance = vsr_pkg::VAR_MAX;
      r.std_dev  = vsr_pkg::STD_MAX;
    end else begin
      r.variance = q[vsr_pkg::VAR_W-1:0];
      root = floor_sqrt({q[47:0], 16'd0}, rem);
      if (rem > root) root = root + 1;
      r.std_dev = (root > 64'(vsr_pkg::STD_MAX)) ? vsr_pkg::STD_MAX : root[31:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    stats_t got;
    stats_t want;
    if (!rst_n) begin
      set_len = 0;
      set_sum = 0;
      corr = vsr_pkg::CORR_RESET;
      mismatches = 0;
      stats_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == vsr_pkg::REG_CORRECTION)
        corr = cfg_pwdata[vsr_pkg::CORR_W-1:0];
      if (in_mon.valid && in_mon.ready) begin
        if (set_len < DEPTH) begin
          set_samples[set_len] = in_mon.sample;
          set_len++;
          set_sum += longint'(in_mon.sample);
        end
        if (in_mon.last) begin
          stats_due = {stats_due, set_stats()};
          set_len = 0;
          set_sum = 0;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.mean, out_mon.variance, out_mon.std_dev, out_mon.empty_set};
        if (stats_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item: %p", got);
        end else begin
          want = stats_due.pop_front();
          if (got.mean !== want.mean || got.variance !== want.variance ||
              got.std_dev !== want.std_dev || got.empty_set !== want.empty_set) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: mean %0d/%0d var %h/%h std %h/%h empty %b/%b (exp/act)",
                       want.mean, got.mean, want.variance, got.variance,
                       want.std_dev, got.std_dev, want.empty_set, got.empty_set);
          end
        end
      end
    end
    pending = stats_due.size();
  end
endmodule

// File: tb/tb_variance_stddev_reduce.sv
// Top of the variance_stddev_reduce testbench: clock, reset, stimulus, verdict.
// Needs vsr_pkg, the channel interfaces, the block and vsr_result_checker.
module tb_variance_stddev_reduce;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW = vsr_pkg::APB_AW;
  localparam logic [AW-1:0] ADDR_CORRECTION = AW'({vsr_pkg::REG_CORRECTION, 2'b00});
  localparam logic [AW-1:0] ADDR_UNUSED     = AW'(3'b100);
  localparam longint CYCLE_LIMIT = 1500000;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int mismatches, pending;
  int idle_pct, stall_pct;
  bit hold_req;
  longint cycles;

  vsr_in_if  in_chan ();
  vsr_out_if out_chan ();

  variance_stddev_reduce DUT (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  vsr_result_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb_variance_stddev_reduce: errors");
        $finish;
      end
    end
  end

  // receiver; a long hold-off lets the block fill up and stall its input
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 0;
      end
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_sample(input logic signed [31:0] s, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.sample <= s;
    in_chan.last   <= l;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic write_reg(input logic [AW-1:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // let the checker queue the final item's prediction before waiting on pending
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (1400) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'($urandom_range(2000)) - 32'sd1000;
      3: return 32'($urandom_range(32'h3FFFF)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_sets(input int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    logic [31:0] corr_list [4];
    corr_list = '{32'd0, 32'd1023, 32'd3, 32'd1};
    rst_n = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    in_chan.valid <= 1'b0;
    in_chan.sample <= '0;
    in_chan.last <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset correction: single samples, extremes, mixed set
    send_sample(32'sh7FFFFFFF, 1'b1);
    send_sample(32'sh80000000, 1'b1);
    send_sample(32'sh7FFFFFFF, 1'b0);
    send_sample(32'sh80000000, 1'b1);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sd0, 1'b1);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd0, 1'b1);
    send_sample(32'sh00010000, 1'b0);
    send_sample(32'sh00030000, 1'b0);
    send_sample(-32'sh00020000, 1'b1);
    drain();
    // correction larger than count clamps divisor to one; unused address ignored
    write_reg(ADDR_CORRECTION, 32'd1023);
    write_reg(ADDR_UNUSED, 32'd0);
    send_sample(32'sh7FFFFFFF, 1'b0);
    send_sample(32'sh80000000, 1'b1);
    // alternating extremes with a divisor of one drive variance into saturation
    for (int i = 0; i < 8; i++)
      send_sample(i[0] ? 32'sh80000000 : 32'sh7FFFFFFF, i == 7);
    drain();

    // pressure: long receiver hold-off while sets keep coming
    write_reg(ADDR_CORRECTION, 32'd0);
    hold_req = 1;
    random_sets(60);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(ADDR_CORRECTION, corr_list[ph] | ($urandom & 32'hFFFFFC00));
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 10 : 58) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 10 : 58) : 0;
      random_sets(85);
      drain();
    end

    if (mismatches == 0) begin
      $display("tb_variance_stddev_reduce: clean");
    end else begin
      $display("tb_variance_stddev_reduce: errors");
    end
    $finish;
  end
endmodule

// File: variance_stddev_reduce.f
+incdir+hdl
hdl/vsr_pkg.sv
hdl/vsr_in_if.sv
hdl/vsr_out_if.sv
hdl/variance_stddev_reduce.sv
tb/vsr_result_checker.sv
tb/tb_variance_stddev_reduce.sv
